[src/decolorize_weight_search_defines.svh]
// Assertion macros shared by the decolorize weight search RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef DECOLORIZE_WEIGHT_SEARCH_DEFINES_SVH
`define DECOLORIZE_WEIGHT_SEARCH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dws_pkg.sv]
// Shared types and constants for the decolorize weight search block.
// No dependencies; used by dws_cell, dws_grey and the top level.
`default_nettype none

package dws_pkg;

  localparam int unsigned WEIGHT_STEPS_DEF = 10;
  localparam int unsigned ACC_BITS_DEF     = 48;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DIFF_W   = PIX_W + 1;
  localparam int unsigned TGT_W    = 11;
  localparam int unsigned WEIGHT_W = 7;
  localparam int unsigned ERR_W    = 48;
  localparam int unsigned OP_W     = 2;

  localparam int unsigned PIX_MAX     = 255;
  localparam int unsigned TGT_MAG_MAX = 1024;
  // Deviation per step count never exceeds 10*255 + 1024.
  localparam int unsigned Q_MAX = 10 * PIX_MAX + TGT_MAG_MAX;
  localparam int unsigned Q_W   = $clog2(Q_MAX + 1);

  localparam logic [WEIGHT_W-1:0] RED_RESET   = 7'd29;
  localparam logic [WEIGHT_W-1:0] GREEN_RESET = 7'd58;
  localparam logic [WEIGHT_W-1:0] BLUE_RESET  = 7'd11;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // Grey = sum / 100 through a reciprocal, exact for sum < 2^15.
  localparam int unsigned GREY_SUM_W = 15;
  localparam int unsigned GREY_K     = 22;
  localparam int unsigned GREY_M_W   = 16;
  localparam logic [GREY_M_W-1:0] GREY_M = 16'd41944;

  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_GREY   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_FINISH = 2'd1,
    OP_PIXEL  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Item travelling down the cell chain.
  typedef struct packed {
    logic                     vld;
    logic                     fin;
    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] dg;
    logic signed [DIFF_W-1:0] db;
    logic signed [TGT_W-1:0]  tgt;
  } link_t;

  // Running best triple handed from cell to cell during a finish.
  typedef struct packed {
    logic                vld;
    logic                have;
    logic [WEIGHT_W-1:0] wr;
    logic [WEIGHT_W-1:0] wg;
    logic [WEIGHT_W-1:0] wb;
  } sel_t;

endpackage

`default_nettype wire

[src/decolorize_weight_search.sv]
// Top level of the decolorize weight search: cell chain, grey unit, output reg.
// Depends on dws_pkg, dws_cell, dws_grey and decolorize_weight_search_defines.svh.
//
//   channel  | dir | handshake             | payload
//   s_axis   | in  | s_axis_tvalid/tready  | tuser: opcode; tdata: two colors, target
//   m_axis   | out | m_axis_tvalid/tready  | tuser: result_kind; tdata: grey, weights, error
//
// Sample pairs are taken one per cycle and ripple down a chain of one cell per
// weight triple, one cell per cycle; each cell has a four-deep deviation pipeline.
// A finish travels the same chain behind the samples; its result leaves the last cell's
// running-minimum stage; a pixel result comes from the grey unit's divide stage.
// Input is held off while a finish or pixel is in flight or the output is stalled.
// Reset clears all accumulators at once and restores weights 29/58/11.
`default_nettype none
`include "decolorize_weight_search_defines.svh"

module decolorize_weight_search #(
  parameter int unsigned WEIGHT_STEPS = dws_pkg::WEIGHT_STEPS_DEF,
  parameter int unsigned ACC_BITS     = dws_pkg::ACC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  // [7:0] red_a, [15:8] green_a, [23:16] blue_a, [31:24] red_b,
  // [39:32] green_b, [47:40] blue_b, [58:48] target_distance
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] result_kind
  output logic [0:0]  m_axis_tuser,
  // [7:0] grey_level, [14:8] weight_red, [21:15] weight_green,
  // [28:22] weight_blue, [76:29] best_error
  output logic [79:0] m_axis_tdata
);

  localparam int unsigned TRIPLES = (WEIGHT_STEPS + 1) * (WEIGHT_STEPS + 2) / 2;
  localparam int unsigned EXT_W   = (ACC_BITS > dws_pkg::ERR_W) ? ACC_BITS
                                                                : dws_pkg::ERR_W;
  localparam int unsigned W_W     = dws_pkg::WEIGHT_W;

  dws_pkg::link_t       chain_link [TRIPLES+1];
  dws_pkg::sel_t        chain_sel  [TRIPLES+1];
  logic [ACC_BITS-1:0]  chain_err  [TRIPLES+1];

  dws_pkg::op_e         op;
  logic                 in_acc, chain_done, grey_done, busy_q, busy_d;
  logic [W_W-1:0]       wr_q, wg_q, wb_q;
  logic                 m_valid_q;
  logic                 m_kind_q;
  logic [79:0]          m_data_q;
  logic [dws_pkg::PIX_W-1:0] grey;
  logic [EXT_W-1:0]     err_ext;
  logic [dws_pkg::ERR_W-1:0] best_err;

  logic [dws_pkg::PIX_W-1:0] red_a, green_a, blue_a, red_b, green_b, blue_b;

  assign red_a   = s_axis_tdata[7:0];
  assign green_a = s_axis_tdata[15:8];
  assign blue_a  = s_axis_tdata[23:16];
  assign red_b   = s_axis_tdata[31:24];
  assign green_b = s_axis_tdata[39:32];
  assign blue_b  = s_axis_tdata[47:40];
  assign op      = dws_pkg::op_e'(s_axis_tuser);

  assign s_axis_tready = !busy_q && (!m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    chain_link[0].vld = in_acc && (op == dws_pkg::OP_SAMPLE || op == dws_pkg::OP_FINISH);
    chain_link[0].fin = (op == dws_pkg::OP_FINISH);
    chain_link[0].dr  = $signed({1'b0, red_a})   - $signed({1'b0, red_b});
    chain_link[0].dg  = $signed({1'b0, green_a}) - $signed({1'b0, green_b});
    chain_link[0].db  = $signed({1'b0, blue_a})  - $signed({1'b0, blue_b});
    chain_link[0].tgt = $signed(s_axis_tdata[58:48]);
  end

  assign chain_sel[0] = '0;
  assign chain_err[0] = '0;

  // Cell order: red steps rising, green steps falling within each red.
  for (genvar r = 0; r <= WEIGHT_STEPS; r++) begin : gen_red
    for (genvar j = 0; j <= WEIGHT_STEPS - r; j++) begin : gen_green
      localparam int IDX = r * (WEIGHT_STEPS + 1) - (r * (r - 1)) / 2 + j;
      dws_cell #(
        .WEIGHT_STEPS (WEIGHT_STEPS),
        .ACC_BITS     (ACC_BITS),
        .RED_STEPS    (r),
        .GREEN_STEPS  (WEIGHT_STEPS - r - j)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .link_i (chain_link[IDX]),
        .link_o (chain_link[IDX+1]),
        .sel_i  (chain_sel[IDX]),
        .err_i  (chain_err[IDX]),
        .sel_o  (chain_sel[IDX+1]),
        .err_o  (chain_err[IDX+1])
      );
    end
  end

  dws_grey u_grey (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (in_acc && op == dws_pkg::OP_PIXEL),
    .wr_i    (wr_q),
    .wg_i    (wg_q),
    .wb_i    (wb_q),
    .red_i   (red_a),
    .green_i (green_a),
    .blue_i  (blue_a),
    .vld_o   (grey_done),
    .grey_o  (grey)
  );

  assign chain_done = chain_sel[TRIPLES].vld;

  always_comb begin
    err_ext  = EXT_W'(chain_err[TRIPLES]);
    best_err = (err_ext > EXT_W'(dws_pkg::ERR_MAX)) ? dws_pkg::ERR_MAX
                                                    : err_ext[dws_pkg::ERR_W-1:0];
    busy_d = busy_q;
    if (chain_done || grey_done) begin
      busy_d = 1'b0;
    end else if (in_acc && (op == dws_pkg::OP_FINISH || op == dws_pkg::OP_PIXEL)) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
      wr_q      <= dws_pkg::RED_RESET;
      wg_q      <= dws_pkg::GREEN_RESET;
      wb_q      <= dws_pkg::BLUE_RESET;
    end else begin
      busy_q <= busy_d;
      if (chain_done || grey_done) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (chain_done) begin
        wr_q <= chain_sel[TRIPLES].wr;
        wg_q <= chain_sel[TRIPLES].wg;
        wb_q <= chain_sel[TRIPLES].wb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_done) begin
      m_kind_q <= dws_pkg::KIND_SEARCH;
      m_data_q <= {3'b000, best_err, chain_sel[TRIPLES].wb, chain_sel[TRIPLES].wg,
                   chain_sel[TRIPLES].wr, 8'd0};
    end else if (grey_done) begin
      m_kind_q <= dws_pkg::KIND_GREY;
      m_data_q <= {3'b000, 48'd0, wb_q, wg_q, wr_q, grey};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = m_data_q;

  `DWS_ASSERT_NOW(a_done_only_busy, chain_done || grey_done, busy_q, "result without request")
  `DWS_ASSERT_NOW(a_no_result_clash, chain_done, !grey_done, "search and grey clash")
  `DWS_ASSERT_NOW(a_out_reg_free, chain_done || grey_done, !m_valid_q || m_axis_tready,
                  "result overwrites pending output")
  `DWS_ASSERT_NEXT(a_busy_after_req,
                   in_acc && (op == dws_pkg::OP_FINISH || op == dws_pkg::OP_PIXEL),
                   busy_q && !s_axis_tready, "request not blocking input")

endmodule

`default_nettype wire

[src/dws_cell.sv]
// One weight-triple cell: deviation pipeline, saturating accumulator and
// running-minimum stage. Depends on dws_pkg.
`default_nettype none

module dws_cell #(
  parameter int unsigned WEIGHT_STEPS = dws_pkg::WEIGHT_STEPS_DEF,
  parameter int unsigned ACC_BITS     = dws_pkg::ACC_BITS_DEF,
  parameter int unsigned RED_STEPS    = 0,
  parameter int unsigned GREEN_STEPS  = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dws_pkg::link_t        link_i,
  output dws_pkg::link_t        link_o,
  input  dws_pkg::sel_t         sel_i,
  input  logic [ACC_BITS-1:0]   err_i,
  output dws_pkg::sel_t         sel_o,
  output logic [ACC_BITS-1:0]   err_o
);

  localparam int unsigned BLUE_STEPS = WEIGHT_STEPS - RED_STEPS - GREEN_STEPS;
  localparam int unsigned MAG_MAX = 10 * WEIGHT_STEPS * dws_pkg::PIX_MAX
                                  + WEIGHT_STEPS * dws_pkg::TGT_MAG_MAX;
  localparam int unsigned MAG_W   = $clog2(MAG_MAX + 1);
  localparam int unsigned D_W     = MAG_W + 1;
  localparam int unsigned RECIP_K = MAG_W + $clog2(WEIGHT_STEPS);
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_K) + WEIGHT_STEPS - 1) / WEIGHT_STEPS;
  localparam int unsigned M_W  = MAG_W + 2;
  localparam int unsigned P_W  = MAG_W + M_W;
  localparam int unsigned SQ_W = 2 * dws_pkg::Q_W;
  localparam int unsigned WR = RED_STEPS * 100 / WEIGHT_STEPS;
  localparam int unsigned WG = GREEN_STEPS * 100 / WEIGHT_STEPS;
  localparam int unsigned WB = BLUE_STEPS * 100 / WEIGHT_STEPS;

  localparam logic signed [D_W-1:0] CR = D_W'(10 * RED_STEPS);
  localparam logic signed [D_W-1:0] CG = D_W'(10 * GREEN_STEPS);
  localparam logic signed [D_W-1:0] CB = D_W'(10 * BLUE_STEPS);
  localparam logic signed [D_W-1:0] CT = D_W'(WEIGHT_STEPS);

  dws_pkg::link_t            link_q;
  logic                      v1_q, f1_q, v2_q, f2_q, v3_q, f3_q;
  logic [MAG_W-1:0]          mag_q;
  logic [dws_pkg::Q_W-1:0]   q_q;
  logic [SQ_W-1:0]           sq_q;
  logic [ACC_BITS-1:0]       acc_q, acc_d;
  dws_pkg::sel_t             sel_q;
  logic [ACC_BITS-1:0]       err_q;

  logic signed [D_W-1:0]     drx, dgx, dbx, tgx, dev;
  logic [MAG_W-1:0]          mag_d;
  logic [P_W-1:0]            prod;
  logic [dws_pkg::Q_W-1:0]   q_d;
  logic [SQ_W-1:0]           sq_d;
  logic [ACC_BITS:0]         acc_sum;
  logic                      take_own;

  always_comb begin
    drx   = D_W'($signed(link_q.dr));
    dgx   = D_W'($signed(link_q.dg));
    dbx   = D_W'($signed(link_q.db));
    tgx   = D_W'($signed(link_q.tgt));
    dev   = CR * drx + CG * dgx + CB * dbx - CT * tgx;
    mag_d = dev[D_W-1] ? MAG_W'(-dev) : MAG_W'(dev);
    // Floor divide by the step count via reciprocal; exact over the range.
    prod  = P_W'(mag_q) * P_W'(RECIP_M);
    q_d   = prod[RECIP_K +: dws_pkg::Q_W];
    sq_d  = SQ_W'(q_q) * SQ_W'(q_q);
    acc_sum = {1'b0, acc_q} + (ACC_BITS + 1)'(sq_q);
    take_own = !sel_i.have || (acc_q < err_i);
    acc_d = acc_q;
    if (v3_q) begin
      if (f3_q) begin
        acc_d = '0;
      end else if (acc_sum[ACC_BITS]) begin
        acc_d = '1;
      end else begin
        acc_d = acc_sum[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
      v1_q   <= 1'b0;
      f1_q   <= 1'b0;
      v2_q   <= 1'b0;
      f2_q   <= 1'b0;
      v3_q   <= 1'b0;
      f3_q   <= 1'b0;
      mag_q  <= '0;
      q_q    <= '0;
      sq_q   <= '0;
      acc_q  <= '0;
      sel_q  <= '0;
      err_q  <= '0;
    end else begin
      link_q    <= link_i;
      v1_q      <= link_q.vld;
      f1_q      <= link_q.fin;
      v2_q      <= v1_q;
      f2_q      <= f1_q;
      v3_q      <= v2_q;
      f3_q      <= f2_q;
      mag_q     <= mag_d;
      q_q       <= q_d;
      sq_q      <= sq_d;
      acc_q     <= acc_d;
      sel_q.vld <= v3_q && f3_q;
      if (v3_q && f3_q) begin
        sel_q.have <= 1'b1;
        if (take_own) begin
          sel_q.wr <= dws_pkg::WEIGHT_W'(WR);
          sel_q.wg <= dws_pkg::WEIGHT_W'(WG);
          sel_q.wb <= dws_pkg::WEIGHT_W'(WB);
          err_q    <= acc_q;
        end else begin
          sel_q.wr <= sel_i.wr;
          sel_q.wg <= sel_i.wg;
          sel_q.wb <= sel_i.wb;
          err_q    <= err_i;
        end
      end
    end
  end

  assign link_o = link_q;
  assign sel_o  = sel_q;
  assign err_o  = err_q;

endmodule

`default_nettype wire

[src/dws_grey.sv]
// Two-stage grey conversion: weighted sum, then divide by 100 and clamp.
// Depends on dws_pkg.
`default_nettype none

module dws_grey (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  logic [dws_pkg::WEIGHT_W-1:0]   wr_i,
  input  logic [dws_pkg::WEIGHT_W-1:0]   wg_i,
  input  logic [dws_pkg::WEIGHT_W-1:0]   wb_i,
  input  logic [dws_pkg::PIX_W-1:0]      red_i,
  input  logic [dws_pkg::PIX_W-1:0]      green_i,
  input  logic [dws_pkg::PIX_W-1:0]      blue_i,
  output logic                           vld_o,
  output logic [dws_pkg::PIX_W-1:0]      grey_o
);

  localparam int unsigned SUM_W  = dws_pkg::GREY_SUM_W;
  localparam int unsigned PROD_W = SUM_W + dws_pkg::GREY_M_W;
  localparam int unsigned QG_W   = PROD_W - dws_pkg::GREY_K;

  logic               v1_q, v2_q;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [PROD_W-1:0]  prod;
  logic [QG_W-1:0]    quo;
  logic [dws_pkg::PIX_W-1:0] grey_q, grey_d;

  always_comb begin
    sum_d = SUM_W'(wr_i) * SUM_W'(red_i) + SUM_W'(wg_i) * SUM_W'(green_i)
          + SUM_W'(wb_i) * SUM_W'(blue_i);
    prod  = PROD_W'(sum_q) * PROD_W'(dws_pkg::GREY_M);
    quo   = prod[dws_pkg::GREY_K +: QG_W];
    grey_d = (quo > QG_W'(dws_pkg::PIX_MAX)) ? dws_pkg::PIX_W'(dws_pkg::PIX_MAX)
                                             : dws_pkg::PIX_W'(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    grey_q <= grey_d;
  end

  assign vld_o  = v2_q;
  assign grey_o = grey_q;

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for decolorize_weight_search: random and directed sample/finish/pixel items,
// checked against an in-bench predictor of the 66 weight-triple error sums.
// Depends on dws_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

  localparam int STEPS = dws_pkg::WEIGHT_STEPS_DEF;
  localparam int N_TRIPLES = (STEPS + 1) * (STEPS + 2) / 2;
  localparam logic [63:0] SUM_SAT = 64'h0000_FFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic                         kind;
    logic [7:0]                   grey;
    logic [dws_pkg::WEIGHT_W-1:0] wr;
    logic [dws_pkg::WEIGHT_W-1:0] wg;
    logic [dws_pkg::WEIGHT_W-1:0] wb;
    logic [dws_pkg::ERR_W-1:0]    err;
  } outcome_t;

  // Shadow of the search state: per-triple error sums, current weights, results due.
  class weight_search_shadow;
    logic [63:0]                  err_sums [N_TRIPLES];
    logic [dws_pkg::WEIGHT_W-1:0] wr, wg, wb;
    outcome_t                     outcomes_due[$];
    int                           failures;

    function new();
      foreach (err_sums[i]) err_sums[i] = '0;
      wr = dws_pkg::RED_RESET;
      wg = dws_pkg::GREEN_RESET;
      wb = dws_pkg::BLUE_RESET;
      failures = 0;
    endfunction

    function void fold_sample(logic [63:0] data);
      int dr, dg, db, tgt, s, d, mag, idx, b;
      logic [63:0] sq, tot;
      dr = int'(data[7:0]) - int'(data[31:24]);
      dg = int'(data[15:8]) - int'(data[39:32]);
      db = int'(data[23:16]) - int'(data[47:40]);
      tgt = int'($signed(data[58:48]));
      idx = 0;
      for (int r = 0; r <= STEPS; r++) begin
        for (int g = STEPS - r; g >= 0; g--) begin
          b = STEPS - r - g;
          s = r * dr + g * dg + b * db;
          d = 10 * s - STEPS * tgt;
          mag = (d < 0) ? -d : d;
          sq = 64'(mag / STEPS) * 64'(mag / STEPS);
          tot = err_sums[idx] + sq;
          err_sums[idx] = (tot > SUM_SAT) ? SUM_SAT : tot;
          idx++;
        end
      end
    endfunction

    function outcome_t pick_weights();
      outcome_t o;
      logic [63:0] best;
      int idx, br, bg;
      idx = 0;
      best = '0;
      br = 0;
      bg = 0;
      // first minimum in triple order wins
      for (int r = 0; r <= STEPS; r++) begin
        for (int g = STEPS - r; g >= 0; g--) begin
          if (idx == 0 || err_sums[idx] < best) begin
            best = err_sums[idx];
            br = r;
            bg = g;
          end
          idx++;
        end
      end
      wr = dws_pkg::WEIGHT_W'(br * 100 / STEPS);
      wg = dws_pkg::WEIGHT_W'(bg * 100 / STEPS);
      wb = dws_pkg::WEIGHT_W'((STEPS - br - bg) * 100 / STEPS);
      foreach (err_sums[i]) err_sums[i] = '0;
      o.kind = dws_pkg::KIND_SEARCH;
      o.grey = '0;
      o.wr = wr;
      o.wg = wg;
      o.wb = wb;
      o.err = dws_pkg::ERR_W'((best > SUM_SAT) ? SUM_SAT : best);
      return o;
    endfunction

    function outcome_t grey_of(logic [63:0] data);
      outcome_t o;
      int unsigned sum;
      sum = wr * data[7:0] + wg * data[15:8] + wb * data[23:16];
      sum = sum / 100;
      o.kind = dws_pkg::KIND_GREY;
      o.grey = (sum > 255) ? 8'd255 : 8'(sum);
      o.wr = wr;
      o.wg = wg;
      o.wb = wb;
      o.err = '0;
      return o;
    endfunction

    function void take_item(dws_pkg::op_e op, logic [63:0] data);
      case (op)
        dws_pkg::OP_SAMPLE: fold_sample(data);
        dws_pkg::OP_FINISH: outcomes_due.push_back(pick_weights());
        dws_pkg::OP_PIXEL:  outcomes_due.push_back(grey_of(data));
        default: ;
      endcase
    endfunction

    function void match_output(logic kind, logic [79:0] data);
      outcome_t x;
      if (outcomes_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: kind %0d data %h", kind, data);
        return;
      end
      x = outcomes_due.pop_front();
      if (kind !== x.kind || data[7:0] !== x.grey || data[14:8] !== x.wr ||
          data[21:15] !== x.wg || data[28:22] !== x.wb || data[76:29] !== x.err) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: exp kind %0d grey %0d w %0d/%0d/%0d err %0d",
                    " | got kind %0d grey %0d w %0d/%0d/%0d err %0d"},
                   x.kind, x.grey, x.wr, x.wg, x.wb, x.err,
                   kind, data[7:0], data[14:8], data[21:15], data[28:22], data[76:29]);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [0:0]  m_axis_tuser;
  logic [79:0] m_axis_tdata;

  weight_search_shadow shadow;
  bit quiet;
  bit hold_req;
  int accepted;

  decolorize_weight_search dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_chan();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] sample_word(logic [7:0] ra, logic [7:0] ga, logic [7:0] ba,
                                              logic [7:0] rb, logic [7:0] gb, logic [7:0] bb,
                                              logic [10:0] tgt);
    return {5'd0, tgt, bb, gb, rb, ba, ga, ra};
  endfunction

  task automatic offer(input dws_pkg::op_e op, input logic [63:0] data);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.take_item(op, data);
    if (op != dws_pkg::OP_NONE) accepted++;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    offer(dws_pkg::OP_PIXEL, sample_word(r, g, b, rand_chan(), rand_chan(), rand_chan(),
                                         11'($urandom_range(0, 2047))));
  endtask

  // Sample whose target follows a hidden weight triple in about half the cases, so the search converges.
  task automatic send_rand_sample();
    logic [7:0] ra, ga, ba, rb, gb, bb;
    int hr, hg, hb, t;
    ra = rand_chan(); ga = rand_chan(); ba = rand_chan();
    rb = rand_chan(); gb = rand_chan(); bb = rand_chan();
    if ($urandom_range(0, 1)) begin
      hr = $urandom_range(0, STEPS);
      hg = $urandom_range(0, STEPS - hr);
      hb = STEPS - hr - hg;
      t = hr * (int'(ra) - int'(rb)) + hg * (int'(ga) - int'(gb)) + hb * (int'(ba) - int'(bb));
      t = t + $urandom_range(0, 10) - 5;
      if (t > 1023) t = 1023;
      if (t < -1024) t = -1024;
    end else begin
      t = $urandom_range(0, 2047);
    end
    offer(dws_pkg::OP_SAMPLE, sample_word(ra, ga, ba, rb, gb, bb, 11'(t)));
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : pick_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      shadow.match_output(m_axis_tuser[0], m_axis_tdata);
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n, waited;
    bit held;
    shadow = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    held = 1'b0;
    accepted = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser <= dws_pkg::OP_NONE;
    s_axis_tdata <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pixels on reset weights, ignored opcode, finish with no samples
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd128);
    offer(dws_pkg::OP_NONE, sample_word(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 11'h3FF));
    offer(dws_pkg::OP_FINISH, '0);
    send_pixel(8'd10, 8'd200, 8'd30);
    // extreme colors and targets
    offer(dws_pkg::OP_SAMPLE, sample_word(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 11'h400));
    offer(dws_pkg::OP_SAMPLE, sample_word(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 11'h3FF));
    offer(dws_pkg::OP_SAMPLE, sample_word(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 11'd0));
    offer(dws_pkg::OP_NONE, '1);
    offer(dws_pkg::OP_FINISH, '0);
    send_pixel(8'd255, 8'd255, 8'd255);
    // all-equal colors, zero target: every sum ties, first triple wins
    offer(dws_pkg::OP_SAMPLE, sample_word(8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 11'd0));
    offer(dws_pkg::OP_FINISH, '0);
    // red-only difference with target at half weight: ties across g/b, first wins
    offer(dws_pkg::OP_SAMPLE, sample_word(8'd20, 8'd5, 8'd9, 8'd10, 8'd5, 8'd9, 11'd50));
    offer(dws_pkg::OP_SAMPLE, sample_word(8'd0, 8'd5, 8'd9, 8'd10, 8'd5, 8'd9, -11'sd50));
    offer(dws_pkg::OP_FINISH, '0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd3, 8'd99, 8'd250);

    accepted = 0;
    while (accepted < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (!held && accepted >= 200) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0)
          offer(dws_pkg::OP_NONE, {5'd0, 59'({$urandom, $urandom})});
        send_rand_sample();
      end
      if ($urandom_range(0, 19) != 0)
        offer(dws_pkg::OP_FINISH, {5'd0, 59'({$urandom, $urandom})});
      repeat ($urandom_range(0, 4))
        send_pixel(rand_chan(), rand_chan(), rand_chan());
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    waited = 0;
    while (shadow.outcomes_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    shadow.failures += shadow.outcomes_due.size();
    if (shadow.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/dws_pkg.sv
src/dws_cell.sv
src/dws_grey.sv
src/decolorize_weight_search.sv
test/tb.sv
